>>> hw/rtl/qwc_pkg.sv
// qwc_pkg: widths, types and constants shared by the Wachspress quad block.
// Depends on nothing; used by qwc_divider and quad_wachspress_coordinates.
`default_nettype none
package qwc_pkg;

   localparam int COORD_BITS = 16;                 // input coordinate width
   localparam int DIFF_BITS  = COORD_BITS + 1;     // corner/point difference
   localparam int PROD_BITS  = 2 * DIFF_BITS;      // one cross-product term
   localparam int CROSS_BITS = PROD_BITS + 1;      // full cross product
   localparam int AREA_BITS  = 2 * COORD_BITS + 1; // doubled unsigned area
   localparam int WGT_BITS   = 3 * AREA_BITS;      // raw weight C*A*A
   localparam int SUM_BITS   = WGT_BITS + 2;       // sum of four raw weights
   localparam int FRAC_BITS  = 16;                 // Q1.16 output
   localparam int OUT_BITS   = FRAC_BITS + 1;
   localparam int LANES      = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [SUM_BITS-1:0]          sum_type;
   typedef logic [OUT_BITS-1:0]          weight_type;

endpackage
`default_nettype wire

>>> hw/rtl/qwc_divider.sv
// qwc_divider: four-lane pipelined restoring divider, floor(num * 2^16 / den).
// One quotient bit per stage; depends on qwc_pkg.
`default_nettype none
module qwc_divider (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic               in_degen,
   input  wire qwc_pkg::sum_type   in_num [qwc_pkg::LANES],
   input  wire qwc_pkg::sum_type   in_den,
   output      logic               out_valid,
   output      logic               out_degen,
   output      qwc_pkg::weight_type out_q [qwc_pkg::LANES]
);

   localparam int NS = qwc_pkg::FRAC_BITS + 1;
   localparam int SB = qwc_pkg::SUM_BITS;
   localparam int OB = qwc_pkg::OUT_BITS;

   logic                 v_ff   [NS];
   logic                 dg_ff  [NS];
   qwc_pkg::sum_type     den_ff [NS];
   qwc_pkg::sum_type     rem_ff [NS][qwc_pkg::LANES];
   qwc_pkg::weight_type  q_ff   [NS][qwc_pkg::LANES];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      qwc_pkg::sum_type    den_src;
      logic                v_src, dg_src;
      logic [SB:0]         trial  [qwc_pkg::LANES];
      qwc_pkg::weight_type q_sh   [qwc_pkg::LANES];
      logic                ge     [qwc_pkg::LANES];
      qwc_pkg::sum_type    rem_in [qwc_pkg::LANES];
      qwc_pkg::weight_type q_in   [qwc_pkg::LANES];

      if (k == 0) begin : g_first
         assign den_src = in_den;
         assign v_src   = in_valid;
         assign dg_src  = in_degen;
         for (genvar l = 0; l < qwc_pkg::LANES; l++) begin : g_src
            assign trial[l] = {1'b0, in_num[l]};
            assign q_sh[l]  = '0;
         end
      end else begin : g_next
         assign den_src = den_ff[k-1];
         assign v_src   = v_ff[k-1];
         assign dg_src  = dg_ff[k-1];
         for (genvar l = 0; l < qwc_pkg::LANES; l++) begin : g_src
            assign trial[l] = {rem_ff[k-1][l], 1'b0};   // remainder < den, fits
            assign q_sh[l]  = {q_ff[k-1][l][OB-2:0], 1'b0};
         end
      end

      for (genvar l = 0; l < qwc_pkg::LANES; l++) begin : g_lane
         always_comb begin
            ge[l] = (trial[l] >= {1'b0, den_src});
            if (ge[l]) begin
               rem_in[l] = SB'(trial[l] - {1'b0, den_src});
               q_in[l]   = {q_sh[l][OB-1:1], 1'b1};
            end else begin
               rem_in[l] = trial[l][SB-1:0];
               q_in[l]   = q_sh[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dg_ff[k]  <= dg_src;
            den_ff[k] <= den_src;
            for (int l = 0; l < qwc_pkg::LANES; l++) begin
               rem_ff[k][l] <= rem_in[l];
               q_ff[k][l]   <= q_in[l];
            end
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_degen = dg_ff[NS-1];
   for (genvar l = 0; l < qwc_pkg::LANES; l++) begin : g_out
      assign out_q[l] = q_ff[NS-1][l];
   end

endmodule
`default_nettype wire

>>> hw/rtl/quad_wachspress_coordinates.sv
// quad_wachspress_coordinates: Wachspress weights of a point in a quad.
// Depends on qwc_pkg and qwc_divider.
//
//   channel | direction | beat contents
//   req_    | in        | point_x/y, corner_0..3_x/y (signed Q8.8)
//   rsp_    | out       | weight_0..3 (unsigned Q1.16), degenerate
//
// The pipeline has 7 arithmetic stages plus 17 divider stages (one
// quotient bit each). One beat is accepted every cycle unless a stalled result holds the pipeline.
// Reset (synchronous) clears only the valid bits of the pipeline.
// A stalled result freezes the whole pipeline (req_ready = !rsp_valid |
// rsp_ready); no beat is lost or repeated.
`default_nettype none
module quad_wachspress_coordinates (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire qwc_pkg::coord_type  req_point_x,
   input  wire qwc_pkg::coord_type  req_point_y,
   input  wire qwc_pkg::coord_type  req_corner_0_x,
   input  wire qwc_pkg::coord_type  req_corner_0_y,
   input  wire qwc_pkg::coord_type  req_corner_1_x,
   input  wire qwc_pkg::coord_type  req_corner_1_y,
   input  wire qwc_pkg::coord_type  req_corner_2_x,
   input  wire qwc_pkg::coord_type  req_corner_2_y,
   input  wire qwc_pkg::coord_type  req_corner_3_x,
   input  wire qwc_pkg::coord_type  req_corner_3_y,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      qwc_pkg::weight_type rsp_weight_0,
   output      qwc_pkg::weight_type rsp_weight_1,
   output      qwc_pkg::weight_type rsp_weight_2,
   output      qwc_pkg::weight_type rsp_weight_3,
   output      logic                rsp_degenerate
);

   localparam int CB = qwc_pkg::COORD_BITS;
   localparam int DB = qwc_pkg::DIFF_BITS;
   localparam int PB = qwc_pkg::PROD_BITS;
   localparam int XB = qwc_pkg::CROSS_BITS;
   localparam int AB = qwc_pkg::AREA_BITS;
   localparam int WB = qwc_pkg::WGT_BITS;
   localparam int SB = qwc_pkg::SUM_BITS;

   // whole pipeline moves when the output slot is empty or being taken
   logic adv;
   logic div_valid;
   logic div_degen;
   qwc_pkg::weight_type div_q [qwc_pkg::LANES];

   assign adv       = !div_valid || rsp_ready;
   assign req_ready = adv;

   logic v_ff [1:7];

   // corner arrays
   qwc_pkg::coord_type vx [4];
   qwc_pkg::coord_type vy [4];
   assign vx[0] = req_corner_0_x;  assign vy[0] = req_corner_0_y;
   assign vx[1] = req_corner_1_x;  assign vy[1] = req_corner_1_y;
   assign vx[2] = req_corner_2_x;  assign vy[2] = req_corner_2_y;
   assign vx[3] = req_corner_3_x;  assign vy[3] = req_corner_3_y;

   // ---- stage 1: differences and the two cross-product terms ----
   // triangles 0..3 are A_i = (P, V_i, V_i+1); 4..7 are C_i = (V_i, V_i+1, V_i-1)
   logic signed [PB-1:0] pa_in [8], pb_in [8];
   logic signed [PB-1:0] pa_ff [8], pb_ff [8];

   always_comb begin
      logic signed [DB-1:0] ox, oy, bx, by, cx, cy, ux, uy, wx, wy;
      for (int t = 0; t < 8; t++) begin
         if (t < 4) begin
            ox = {req_point_x[CB-1], req_point_x};
            oy = {req_point_y[CB-1], req_point_y};
            bx = {vx[t][CB-1], vx[t]};
            by = {vy[t][CB-1], vy[t]};
            cx = {vx[(t+1)%4][CB-1], vx[(t+1)%4]};
            cy = {vy[(t+1)%4][CB-1], vy[(t+1)%4]};
         end else begin
            ox = {vx[t%4][CB-1], vx[t%4]};
            oy = {vy[t%4][CB-1], vy[t%4]};
            bx = {vx[(t+1)%4][CB-1], vx[(t+1)%4]};
            by = {vy[(t+1)%4][CB-1], vy[(t+1)%4]};
            cx = {vx[(t+3)%4][CB-1], vx[(t+3)%4]};
            cy = {vy[(t+3)%4][CB-1], vy[(t+3)%4]};
         end
         ux = bx - ox;  uy = by - oy;
         wx = cx - ox;  wy = cy - oy;
         pa_in[t] = ux * wy;
         pb_in[t] = uy * wx;
      end
   end

   // ---- stage 2: cross product and absolute value -> doubled areas ----
   logic [AB-1:0] area_in [8];
   logic [AB-1:0] area_ff [8];

   always_comb begin
      logic signed [XB-1:0] cr;
      logic signed [XB-1:0] mag;
      for (int t = 0; t < 8; t++) begin
         cr  = XB'(pa_ff[t]) - XB'(pb_ff[t]);
         mag = (cr < 0) ? -cr : cr;
         area_in[t] = mag[AB-1:0];     // |cross| < 2^AB
      end
   end

   // ---- stage 3: C_i * A_i+1, carry A_i+2 along ----
   logic [2*AB-1:0] m_in  [4], m_ff [4];
   logic [AB-1:0]   a2_ff [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         m_in[i] = area_ff[4+i] * area_ff[(i+1)%4];
      end
   end

   // ---- stage 4: split the wide product into two partial products ----
   logic [2*AB-1:0] lo_in [4], hi_in [4];
   logic [2*AB-1:0] lo_ff [4], hi_ff [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lo_in[i] = m_ff[i][AB-1:0]    * a2_ff[i];
         hi_in[i] = m_ff[i][2*AB-1:AB] * a2_ff[i];
      end
   end

   // ---- stage 5: recombine into raw weights ----
   logic [WB-1:0] w_in [4], w5_ff [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         w_in[i] = WB'(lo_ff[i]) + (WB'(hi_ff[i]) << AB);
      end
   end

   // ---- stage 6: pairwise sums ----
   logic [SB-1:0] s01_ff, s23_ff;
   logic [WB-1:0] w6_ff [4];

   // ---- stage 7: total and degenerate test ----
   qwc_pkg::sum_type sum_in;
   qwc_pkg::sum_type sum_ff;
   qwc_pkg::sum_type num_ff [qwc_pkg::LANES];
   logic             dg_ff;

   assign sum_in = s01_ff + s23_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= 7; s++) v_ff[s] <= 1'b0;
      end else if (adv) begin
         v_ff[1] <= req_valid;
         for (int s = 2; s <= 7; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         area_ff <= area_in;
         for (int i = 0; i < 4; i++) begin
            m_ff[i]  <= m_in[i];
            a2_ff[i] <= area_ff[(i+2)%4];
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_in[i];
            w5_ff[i] <= w_in[i];
            w6_ff[i] <= w5_ff[i];
            num_ff[i] <= SB'(w6_ff[i]);
         end
         s01_ff <= SB'(w5_ff[0]) + SB'(w5_ff[1]);
         s23_ff <= SB'(w5_ff[2]) + SB'(w5_ff[3]);
         sum_ff <= sum_in;
         dg_ff  <= (sum_in == '0);
      end
   end

   // ---- stages 8..24: one quotient bit per stage ----
   qwc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v_ff[7]),
      .in_degen  (dg_ff),
      .in_num    (num_ff),
      .in_den    (sum_ff),
      .out_valid (div_valid),
      .out_degen (div_degen),
      .out_q     (div_q)
   );

   // degenerate quad forces all weights to zero
   assign rsp_valid      = div_valid;
   assign rsp_degenerate = div_degen;
   assign rsp_weight_0   = div_degen ? '0 : div_q[0];
   assign rsp_weight_1   = div_degen ? '0 : div_q[1];
   assign rsp_weight_2   = div_degen ? '0 : div_q[2];
   assign rsp_weight_3   = div_degen ? '0 : div_q[3];

endmodule
`default_nettype wire

>>> hw/rtl/qwc_checker.sv
// qwc_checker: port-level assertions for quad_wachspress_coordinates.
// Depends on qwc_pkg; bound to the top level below.
`default_nettype none
module qwc_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire qwc_pkg::weight_type rsp_weight_0,
   input wire qwc_pkg::weight_type rsp_weight_1,
   input wire qwc_pkg::weight_type rsp_weight_2,
   input wire qwc_pkg::weight_type rsp_weight_3,
   input wire logic                rsp_degenerate
);

   logic [qwc_pkg::OUT_BITS+1:0] wsum;
   assign wsum = (qwc_pkg::OUT_BITS+2)'(rsp_weight_0) + (qwc_pkg::OUT_BITS+2)'(rsp_weight_1)
               + (qwc_pkg::OUT_BITS+2)'(rsp_weight_2) + (qwc_pkg::OUT_BITS+2)'(rsp_weight_3);

   // stalled result beat holds (valid, weight_0, weight_3 and degenerate are checked)
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weight_0) && $stable(rsp_weight_3)
         && $stable(rsp_degenerate))
      else $error("stalled result changed");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> wsum == '0)
      else $error("degenerate beat with nonzero weight");

   a_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> wsum <= (1 << qwc_pkg::FRAC_BITS))
      else $error("weights sum above one");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind quad_wachspress_coordinates qwc_checker u_qwc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_weight_0   (rsp_weight_0),
   .rsp_weight_1   (rsp_weight_1),
   .rsp_weight_2   (rsp_weight_2),
   .rsp_weight_3   (rsp_weight_3),
   .rsp_degenerate (rsp_degenerate)
);
`default_nettype wire

>>> verif/tb_quad_wachspress_coordinates.sv
// Testbench for quad_wachspress_coordinates: directed and random quads checked
// against an exact integer Wachspress predictor. Depends on qwc_pkg and the RTL.
`default_nettype none
module tb_quad_wachspress_coordinates;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = qwc_pkg::COORD_BITS;
   localparam int FRAC_BITS  = qwc_pkg::FRAC_BITS;
   localparam int OUT_BITS   = qwc_pkg::OUT_BITS;
   localparam int LANES      = qwc_pkg::LANES;

   localparam int HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int STALL_LIMIT = 5000;  // cycles with no beat before giving up
   localparam int DRAIN_WAIT  = 40;    // past the pipeline depth

   // one request beat: [0]=px [1]=py [2+2i]=corner i x [3+2i]=corner i y
   typedef logic [9:0][COORD_BITS-1:0] quad_beat_type;

   typedef struct packed {
      logic [LANES-1:0][OUT_BITS-1:0] weight;
      logic                           degenerate;
   } weights_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   quad_beat_type req_beat = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   qwc_pkg::weight_type rsp_weight_0, rsp_weight_1, rsp_weight_2, rsp_weight_3;
   logic rsp_degenerate;

   weights_type expected_weights[$];
   int send_idle_pct = 0;     // sender idles in this many cycles of a hundred
   int recv_stall_pct = 0;    // receiver stalls likewise
   int hold_requests = 0;     // bumped by a test to ask for a long hold-off
   int hold_served = 0;
   int hold_left = 0;
   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int degenerate_seen = 0;
   int quiet_cycles = 0;

   always #6 clock = ~clock;

   quad_wachspress_coordinates dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_point_x    (req_beat[0]),
      .req_point_y    (req_beat[1]),
      .req_corner_0_x (req_beat[2]),
      .req_corner_0_y (req_beat[3]),
      .req_corner_1_x (req_beat[4]),
      .req_corner_1_y (req_beat[5]),
      .req_corner_2_x (req_beat[6]),
      .req_corner_2_y (req_beat[7]),
      .req_corner_3_x (req_beat[8]),
      .req_corner_3_y (req_beat[9]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_weight_0   (rsp_weight_0),
      .rsp_weight_1   (rsp_weight_1),
      .rsp_weight_2   (rsp_weight_2),
      .rsp_weight_3   (rsp_weight_3),
      .rsp_degenerate (rsp_degenerate)
   );

   // twice the unsigned area of triangle (a, b, c)
   function automatic logic [127:0] tri_area2(input longint ax, ay, bx, by, cx, cy);
      longint cr;
      cr = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
      if (cr < 0) cr = -cr;
      return 128'(cr);
   endfunction

   // exact weights: w_i = C_i * A_i+1 * A_i+2, output floor(w_i * 2^16 / sum)
   function automatic weights_type wachspress_weights(input quad_beat_type q);
      longint px, py;
      longint vx[4], vy[4];
      logic [127:0] a[4], c[4], w[4], total, quo;
      weights_type r;
      px = longint'($signed(q[0]));
      py = longint'($signed(q[1]));
      for (int i = 0; i < 4; i++) begin
         vx[i] = longint'($signed(q[2 + 2 * i]));
         vy[i] = longint'($signed(q[3 + 2 * i]));
      end
      for (int i = 0; i < 4; i++) begin
         a[i] = tri_area2(px, py, vx[i], vy[i], vx[(i + 1) % 4], vy[(i + 1) % 4]);
         c[i] = tri_area2(vx[i], vy[i], vx[(i + 1) % 4], vy[(i + 1) % 4],
                          vx[(i + 3) % 4], vy[(i + 3) % 4]);
      end
      total = '0;
      for (int i = 0; i < 4; i++) begin
         w[i] = c[i] * a[(i + 1) % 4] * a[(i + 2) % 4];
         total += w[i];
      end
      r = '0;
      if (total == 0) begin
         r.degenerate = 1'b1;
      end else begin
         for (int i = 0; i < 4; i++) begin
            quo = (w[i] << FRAC_BITS) / total;
            r.weight[i] = quo[OUT_BITS-1:0];
         end
      end
      return r;
   endfunction

   // drive one beat; hold it until accepted, then queue its prediction
   task automatic send_quad(input quad_beat_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_weights.push_back(wachspress_weights(q));
      beats_sent++;
   endtask

   function automatic quad_beat_type random_quad();
      quad_beat_type q;
      int cx, cy, sz, j;
      int kind;
      kind = $urandom_range(99);
      if (kind < 35) begin
         // raw noise over the full range of every field
         for (int k = 0; k < 10; k++) q[k] = COORD_BITS'($urandom);
      end else begin
         // jittered square with a point near it
         sz = $urandom_range(1, (kind < 45) ? 16000 : 300);
         cx = $urandom_range(0, 40000) - 20000;
         cy = $urandom_range(0, 40000) - 20000;
         j  = sz / 3 + 1;
         q[2] = COORD_BITS'(cx - sz + $urandom_range(0, j));
         q[3] = COORD_BITS'(cy - sz + $urandom_range(0, j));
         q[4] = COORD_BITS'(cx + sz - $urandom_range(0, j));
         q[5] = COORD_BITS'(cy - sz + $urandom_range(0, j));
         q[6] = COORD_BITS'(cx + sz - $urandom_range(0, j));
         q[7] = COORD_BITS'(cy + sz - $urandom_range(0, j));
         q[8] = COORD_BITS'(cx - sz + $urandom_range(0, j));
         q[9] = COORD_BITS'(cy + sz - $urandom_range(0, j));
         q[0] = COORD_BITS'(cx + $urandom_range(0, 3 * sz) - (3 * sz) / 2);
         q[1] = COORD_BITS'(cy + $urandom_range(0, 3 * sz) - (3 * sz) / 2);
         // sometimes collapse corners or snap the point onto a corner
         if (kind > 94) begin
            q[6] = q[4];
            q[7] = q[5];
            q[8] = q[2];
            q[9] = q[3];
         end else if (kind > 90) begin
            q[0] = q[2 + 2 * (kind % 4)];
            q[1] = q[3 + 2 * (kind % 4)];
         end
      end
      return q;
   endfunction

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) send_quad(random_quad());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_weights.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      quad_beat_type q;
      // all zero: degenerate
      send_quad('0);
      // every field at max, then at min: corners coincide, degenerate
      send_quad({10{16'h7fff}});
      send_quad({10{16'h8000}});
      // full-range square, point at center, at each corner, then at corner 0 again
      q = {16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
           16'h8000, 16'h8000, 16'h0000, 16'h0000};
      send_quad(q);
      for (int i = 0; i < 4; i++) begin
         q[0] = q[2 + 2 * i];
         q[1] = q[3 + 2 * i];
         send_quad(q);
      end
      q[0] = 16'h8000;
      q[1] = 16'h8000;
      send_quad(q);
      // unit square in Q8.8, point at center and off to one side
      q = {16'h0100, 16'h0000, 16'h0100, 16'h0100, 16'h0000, 16'h0100,
           16'h0000, 16'h0000, 16'h0080, 16'h0080};
      send_quad(q);
      q[0] = 16'h0300;
      q[1] = 16'hff00;
      send_quad(q);
      // point on an edge
      q[0] = 16'h0080;
      q[1] = 16'h0000;
      send_quad(q);
      // collinear corners: degenerate
      q = {16'h0300, 16'h0300, 16'h0200, 16'h0200, 16'h0100, 16'h0100,
           16'h0000, 16'h0000, 16'h0050, 16'h0010};
      send_quad(q);
      // alternating extremes across fields
      send_quad({5{16'h7fff, 16'h8000}});
      send_quad({5{16'h8000, 16'h7fff}});
      send_quad({10{16'hffff}});
      send_quad({10{16'h0001}});
      send_quad({16'h0001, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h0001,
                 16'hffff, 16'hffff, 16'h0000, 16'h0000});
      wait_drained();
   endtask

   task automatic test_random_sender_light();
      send_idle_pct  = 13;
      recv_stall_pct = 53;
      send_random(550);
      wait_drained();
   endtask

   task automatic test_random_receiver_light();
      send_idle_pct  = 53;
      recv_stall_pct = 13;
      send_random(500);
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering: pipeline fills
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      send_random(80);
      wait_drained();
   endtask

   task automatic test_random_no_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random(500);
      wait_drained();
   endtask

   // receiver: random stalls, or a counted hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_ready   <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_requests;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result checker: compare each accepted beat with the oldest prediction
   always @(posedge clock) begin
      weights_type want;
      weights_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.weight     = {rsp_weight_3, rsp_weight_2, rsp_weight_1, rsp_weight_0};
         got.degenerate = rsp_degenerate;
         if (expected_weights.size() == 0) begin
            $error("result beat with no prediction waiting");
            errors++;
         end else begin
            want = expected_weights.pop_front();
            for (int i = 0; i < LANES; i++)
               if (got.weight[i] !== want.weight[i]) begin
                  $error("weight_%0d expected %0d actual %0d", i, want.weight[i],
                         got.weight[i]);
                  errors++;
               end
            if (got.degenerate !== want.degenerate) begin
               $error("degenerate expected %0d actual %0d", want.degenerate,
                      got.degenerate);
               errors++;
            end
            if (want.degenerate) degenerate_seen++;
            beats_checked++;
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("quad_wachspress_coordinates test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_sender_light();
      test_random_receiver_light();
      test_backpressure();
      test_random_no_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_weights.size() != 0) begin
         $error("%0d predictions never answered", expected_weights.size());
         errors++;
      end
      $display("covered %0d quads (%0d degenerate), %0d results checked,",
               beats_sent, degenerate_seen, beats_checked);
      $display("under sender idling, receiver stalls and one long hold-off");
      if (errors == 0) begin
         $display("quad_wachspress_coordinates test passed");
      end else begin
         $display("quad_wachspress_coordinates test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> quad_wachspress_coordinates.f
hw/rtl/qwc_pkg.sv
hw/rtl/qwc_divider.sv
hw/rtl/quad_wachspress_coordinates.sv
hw/rtl/qwc_checker.sv
verif/tb_quad_wachspress_coordinates.sv
